// ===== design/orq_pkg.sv =====
// types, codes and the ordering rule shared by the ordered ready queue
// no dependencies; used by orq_cell and ordered_ready_queue
package orq_pkg;

  localparam int PID_W  = 15;
  localparam int PRI_W  = 8;
  localparam int TIME_W = 16;
  localparam int OCC_W  = 6;

  typedef struct packed {
    logic [PRI_W-1:0]  priority_req;
    logic [TIME_W-1:0] run_time;
    logic [PID_W-1:0]  pid;
  } entry_t;

  // command carried in s_axis_tuser
  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_POP    = 1'b1
  } cmd_t;

  // status carried in m_axis_tuser
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // broadcast from the top level to every cell
  typedef struct packed {
    logic   insert;
    logic   pop;
    entry_t new_entry;
  } cell_ctl_t;

  // true when a must stand before b
  function automatic logic beats(entry_t a, entry_t b);
    logic r;
    if (a.priority_req != b.priority_req) begin
      r = a.priority_req > b.priority_req;
    end else if (a.run_time != b.run_time) begin
      r = a.run_time < b.run_time;
    end else begin
      r = a.pid < b.pid;
    end
    return r;
  endfunction

endpackage

// ===== design/orq_cell.sv =====
// one position of the sorted queue: holds an entry, compares it with the
// broadcast insert, shifts toward the tail on insert and toward the head on pop
// depends on orq_pkg
module orq_cell (
  input  logic               clk,
  input  logic               rst,
  input  orq_pkg::cell_ctl_t ctl,
  input  orq_pkg::entry_t    left_entry,
  input  logic               left_valid,
  input  logic               left_beat,
  input  orq_pkg::entry_t    right_entry,
  input  logic               right_valid,
  output orq_pkg::entry_t    entry,
  output logic               valid,
  output logic               beat
);
  import orq_pkg::*;

  logic take;

  // new entry goes ahead of this one; sorted order makes this monotone along the row
  assign beat = valid & beats(ctl.new_entry, entry);
  // this cell changes on insert if it is displaced or is the first free slot
  assign take = beat | (~valid & left_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.pop) begin
      valid <= right_valid;
    end else if (ctl.insert && take) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      entry <= right_entry;
    end else if (ctl.insert && take) begin
      entry <= left_beat ? left_entry : ctl.new_entry;
    end
  end

endmodule

// ===== design/ordered_ready_queue.sv =====
// top level of the ordered ready queue: a row of orq_cell positions,
// the entry count and the result register; depends on orq_pkg and orq_cell
//
// Usage: each item on s_axis is a command. Insert (tuser 0) places the entry
// from tdata in sorted order: higher priority first, then smaller remaining
// time, then smaller pid; ties go behind entries already held. Pop (tuser 1)
// removes the head and returns it on m_axis. Every item gives one result item
// with a status in m_axis_tuser: done, insert rejected on a full queue, or pop
// on an empty queue, plus the occupancy after the command.
// Throughput is one item per cycle while m_axis keeps up: every cell compares
// the new entry with its own at once and shifts with its neighbor in the same
// edge; no search runs over the row. m_axis_tvalid rises in the next cycle.
// The result register frees when m_axis takes the item, so a new item is
// accepted in the same cycle a waiting result leaves. While the receiver
// stalls, s_axis_tready stays low and the queue holds.
// Reset empties the queue and drops any waiting result; no clearing pass.
module ordered_ready_queue #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // pid[14:0], priority_req[22:15], run_time[38:23]
  input  logic [0:0]  s_axis_tuser,   // command[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // out_pid[14:0], out_priority[22:15],
                                      // out_run_time[38:23], occupancy[44:39]
  output logic [1:0]  m_axis_tuser    // status[1:0]
);
  import orq_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic             accept;
  logic             is_pop;
  logic             full;
  logic             empty;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  cell_ctl_t        ctl;
  entry_t           in_entry;

  entry_t           cell_entry [QUEUE_DEPTH];
  logic             cell_valid [QUEUE_DEPTH];
  logic             cell_beat  [QUEUE_DEPTH];

  status_t          status;
  status_t          status_next;
  entry_t           out_entry;
  entry_t           out_entry_next;
  logic [OCC_W-1:0] occupancy;
  logic             out_valid;

  assign s_axis_tready = ~out_valid | m_axis_tready;
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign is_pop        = (s_axis_tuser[0] == CMD_POP);
  assign full          = (count == CNT_W'(QUEUE_DEPTH));
  assign empty         = (count == '0);

  assign in_entry.pid          = s_axis_tdata[14:0];
  assign in_entry.priority_req = s_axis_tdata[22:15];
  assign in_entry.run_time     = s_axis_tdata[38:23];

  assign ctl.insert    = accept & ~is_pop & ~full;
  assign ctl.pop       = accept & is_pop & ~empty;
  assign ctl.new_entry = in_entry;

  always_comb begin
    count_next = count;
    if (ctl.insert) begin
      count_next = count + CNT_W'(1);
    end else if (ctl.pop) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_comb begin
    status_next    = ST_DONE;
    out_entry_next = '0;
    if (is_pop) begin
      if (empty) begin
        status_next = ST_EMPTY;
      end else begin
        out_entry_next = cell_entry[0];
      end
    end else if (full) begin
      status_next = ST_FULL;
    end
  end

  genvar g;
  generate
    for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      entry_t l_entry;
      logic   l_valid;
      logic   l_beat;
      entry_t r_entry;
      logic   r_valid;
      if (g == 0) begin : g_head
        // the head sees a full, non-beaten neighbor so it takes the new entry
        assign l_entry = '0;
        assign l_valid = 1'b1;
        assign l_beat  = 1'b0;
      end else begin : g_mid
        assign l_entry = cell_entry[g-1];
        assign l_valid = cell_valid[g-1];
        assign l_beat  = cell_beat[g-1];
      end
      if (g == QUEUE_DEPTH - 1) begin : g_tail
        assign r_entry = '0;
        assign r_valid = 1'b0;
      end else begin : g_body
        assign r_entry = cell_entry[g+1];
        assign r_valid = cell_valid[g+1];
      end
      orq_cell u_cell (
        .clk         (clk),
        .rst         (rst),
        .ctl         (ctl),
        .left_entry  (l_entry),
        .left_valid  (l_valid),
        .left_beat   (l_beat),
        .right_entry (r_entry),
        .right_valid (r_valid),
        .entry       (cell_entry[g]),
        .valid       (cell_valid[g]),
        .beat        (cell_beat[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status    <= status_next;
      out_entry <= out_entry_next;
      occupancy <= OCC_W'(count_next);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = status;
  assign m_axis_tdata  = {3'b000, occupancy, out_entry.run_time,
                          out_entry.priority_req, out_entry.pid};

endmodule
